/* sv/lj_pkg.sv */
package lj_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int ENERGY_W      = 48;
    localparam int ADDR_W        = 4;

    localparam logic [PROD_W-1:0] E_POS_LIM = (PROD_W'(1) << (ENERGY_W - 1)) - PROD_W'(1);
    localparam logic [PROD_W-1:0] E_NEG_LIM = PROD_W'(1) << (ENERGY_W - 1);

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_SIGMA   = 2'd1,
        REG_EPSILON = 2'd2,
        REG_CUTOFF  = 2'd3
    } lj_reg_t;

    typedef struct packed {
        logic valid;
        logic zero;
        logic sat;
    } lj_tag_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] energy;
        logic                       sat;
    } lj_res_t;

endpackage

/* sv/lj_div.sv */
module lj_div import lj_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [WORD_W-1:0] sigma_i,
    input  logic [WORD_W-1:0] dist_i,
    input  lj_tag_t           tag_i,
    output logic [WORD_W-1:0] q_o,
    output lj_tag_t           tag_o
);

    localparam int HI_SHIFT = WORD_W - FRAC_BITS;
    localparam int STAGES   = WORD_W;

    logic [WORD_W-1:0] rem_reg [0:STAGES];
    logic [WORD_W-1:0] ql_reg  [0:STAGES];
    logic [WORD_W-1:0] den_reg [0:STAGES];
    lj_tag_t           tag_reg [0:STAGES];

    logic [WORD_W-1:0] rem_next [0:STAGES-1];
    logic [WORD_W-1:0] ql_next  [0:STAGES-1];
    logic [WORD_W:0]   trial_next [0:STAGES-1];
    logic              ge_next  [0:STAGES-1];

    logic [WORD_W-1:0] hi_part;
    logic              ovf;

    assign hi_part = WORD_W'(sigma_i >> HI_SHIFT);
    assign ovf     = hi_part >= dist_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (advance) begin
            tag_reg[0] <= '{valid: tag_i.valid, zero: tag_i.zero, sat: tag_i.sat | ovf};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg[0] <= hi_part;
            ql_reg[0]  <= {sigma_i[HI_SHIFT-1:0], {FRAC_BITS{1'b0}}};
            den_reg[0] <= dist_i;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        assign trial_next[k] = {rem_reg[k], ql_reg[k][WORD_W-1]};
        assign ge_next[k]    = trial_next[k] >= {1'b0, den_reg[k]};
        assign rem_next[k]   = ge_next[k] ? WORD_W'(trial_next[k] - {1'b0, den_reg[k]})
                                          : trial_next[k][WORD_W-1:0];
        assign ql_next[k]    = {ql_reg[k][WORD_W-2:0], ge_next[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k+1] <= '0;
            end else if (advance) begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                rem_reg[k+1] <= rem_next[k];
                ql_reg[k+1]  <= ql_next[k];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign q_o   = tag_reg[STAGES].sat ? '1 : ql_reg[STAGES];
    assign tag_o = tag_reg[STAGES];

endmodule

/* sv/lj_fxmul.sv */
module lj_fxmul import lj_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [WORD_W-1:0] a_i,
    input  logic [WORD_W-1:0] b_i,
    input  logic [WORD_W-1:0] aux_i,
    input  lj_tag_t           tag_i,
    output logic [WORD_W-1:0] p_o,
    output logic [WORD_W-1:0] aux_o,
    output lj_tag_t           tag_o
);

    localparam int TOP = WORD_W + FRAC_BITS;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] aux1_reg, aux2_reg;
    lj_tag_t           tag1_reg, tag2_reg;
    logic [WORD_W-1:0] p_reg, p_next;
    logic              ovf;

    assign prod_next = PROD_W'(a_i) * PROD_W'(b_i);
    assign ovf       = |prod_reg[PROD_W-1:TOP];
    assign p_next    = ovf ? '1 : prod_reg[TOP-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else if (advance) begin
            tag1_reg <= tag_i;
            tag2_reg <= '{valid: tag1_reg.valid, zero: tag1_reg.zero, sat: tag1_reg.sat | ovf};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
            aux1_reg <= aux_i;
            p_reg    <= p_next;
            aux2_reg <= aux1_reg;
        end
    end

    assign p_o   = p_reg;
    assign aux_o = aux2_reg;
    assign tag_o = tag2_reg;

endmodule

/* sv/lennard_jones_pair_energy.sv */
// Throughput: one beat per cycle unless a full output queue stalls the pipeline;
// the 32-stage restoring divider and the five pipelined 32x32 multipliers each take
// a new operand every cycle in which the pipeline advances.
// A two-entry output queue keeps s_ready high while one result waits.
// Reset (aresetn low, synchronous): config registers clear to 0, pipeline and queue empty.
module lennard_jones_pair_energy import lj_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [WORD_W-1:0]          pwdata,
    output logic [WORD_W-1:0]          prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [WORD_W-1:0]          s_distance,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [ENERGY_W-1:0] m_energy,
    output logic                       m_saturated
);

    localparam int E_SHIFT = FRAC_BITS - 2;

    logic              enable_reg;
    logic [WORD_W-1:0] sigma_reg, eps_reg, cutoff_reg;
    lj_reg_t           reg_sel;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = lj_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            sigma_reg  <= '0;
            eps_reg    <= '0;
            cutoff_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_ENABLE:  enable_reg <= pwdata[0];
                REG_SIGMA:   sigma_reg  <= pwdata;
                REG_EPSILON: eps_reg    <= pwdata;
                REG_CUTOFF:  cutoff_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ENABLE:  prdata = {{(WORD_W-1){1'b0}}, enable_reg};
            REG_SIGMA:   prdata = sigma_reg;
            REG_EPSILON: prdata = eps_reg;
            REG_CUTOFF:  prdata = cutoff_reg;
            default:     prdata = '0;
        endcase
    end

    logic    advance;
    lj_tag_t tag_in;

    assign s_ready = advance;
    assign tag_in  = '{valid: s_valid,
                       zero: !enable_reg || (s_distance >= cutoff_reg),
                       sat: 1'b0};

    logic [WORD_W-1:0] q, q2, q3, s, s2, q_aux, s_aux;
    lj_tag_t           tag_q, tag_q2, tag_q3, tag_s, tag_s2;

    lj_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk, .aresetn, .advance,
        .sigma_i(sigma_reg), .dist_i(s_distance), .tag_i(tag_in),
        .q_o(q), .tag_o(tag_q)
    );

    lj_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_q2 (
        .aclk, .aresetn, .advance,
        .a_i(q), .b_i(q), .aux_i(q), .tag_i(tag_q),
        .p_o(q2), .aux_o(q_aux), .tag_o(tag_q2)
    );

    lj_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_q3 (
        .aclk, .aresetn, .advance,
        .a_i(q2), .b_i(q_aux), .aux_i(q2), .tag_i(tag_q2),
        .p_o(q3), .aux_o(), .tag_o(tag_q3)
    );

    lj_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_s (
        .aclk, .aresetn, .advance,
        .a_i(q3), .b_i(q3), .aux_i(q3), .tag_i(tag_q3),
        .p_o(s), .aux_o(), .tag_o(tag_s)
    );

    lj_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_s2 (
        .aclk, .aresetn, .advance,
        .a_i(s), .b_i(s), .aux_i(s), .tag_i(tag_s),
        .p_o(s2), .aux_o(s_aux), .tag_o(tag_s2)
    );

    // difference and epsilon magnitude
    logic [WORD_W-1:0] dmag_reg, dmag_next, emag_reg, emag_next;
    logic              xneg_reg, xneg_next, dneg;
    lj_tag_t           tag_d_reg;

    assign dneg      = s2 < s_aux;
    assign dmag_next = dneg ? (s_aux - s2) : (s2 - s_aux);
    assign emag_next = eps_reg[WORD_W-1] ? (~eps_reg + WORD_W'(1)) : eps_reg;
    assign xneg_next = dneg ^ eps_reg[WORD_W-1];

    // scale product
    logic [PROD_W-1:0] emul_reg, emul_next;
    logic              xneg_m_reg;
    lj_tag_t           tag_m_reg;

    assign emul_next = PROD_W'(emag_reg) * PROD_W'(dmag_reg);

    // shift, saturate, zero forcing
    logic [PROD_W-1:0] mag;
    logic              eneg, esat;
    lj_res_t           res_reg, res_next;
    lj_tag_t           tag_r_reg;

    always_comb begin
        mag  = emul_reg >> E_SHIFT;
        eneg = xneg_m_reg && (mag != '0);
        esat = 1'b0;
        if (eneg) begin
            if (mag > E_NEG_LIM) begin
                mag  = E_NEG_LIM;
                esat = 1'b1;
            end
            res_next.energy = ENERGY_W'(PROD_W'(0) - mag);
        end else begin
            if (mag > E_POS_LIM) begin
                mag  = E_POS_LIM;
                esat = 1'b1;
            end
            res_next.energy = ENERGY_W'(mag);
        end
        res_next.sat = tag_m_reg.sat | esat;
        if (tag_m_reg.zero) begin
            res_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_d_reg <= '0;
            tag_m_reg <= '0;
            tag_r_reg <= '0;
        end else if (advance) begin
            tag_d_reg <= tag_s2;
            tag_m_reg <= tag_d_reg;
            tag_r_reg <= tag_m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dmag_reg   <= dmag_next;
            emag_reg   <= emag_next;
            xneg_reg   <= xneg_next;
            emul_reg   <= emul_next;
            xneg_m_reg <= xneg_reg;
            res_reg    <= res_next;
        end
    end

    // two-entry output queue
    logic [1:0] count_reg, count_next;
    lj_res_t    out_reg, out_next, skid_reg, skid_next;
    logic       push, pop;

    assign advance = !tag_r_reg.valid || (count_reg != 2'd2);
    assign push    = advance && tag_r_reg.valid;
    assign pop     = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        out_next   = out_reg;
        skid_next  = skid_reg;
        case ({push, pop})
            2'b11: begin
                if (count_reg == 2'd1) begin
                    out_next = res_reg;
                end else begin
                    out_next  = skid_reg;
                    skid_next = res_reg;
                end
            end
            2'b10: begin
                if (count_reg == 2'd0) begin
                    out_next = res_reg;
                end else begin
                    skid_next = res_reg;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                out_next   = skid_reg;
                count_next = count_reg - 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid     = count_reg != 2'd0;
    assign m_energy    = out_reg.energy;
    assign m_saturated = out_reg.sat;

endmodule

/* sv/lj_chk.sv */
module lj_chk import lj_pkg::*; (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [ADDR_W-1:0]          paddr,
    input logic [WORD_W-1:0]          pwdata,
    input logic                       pready,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [ENERGY_W-1:0] m_energy,
    input logic                       m_saturated
);

    logic       en_reg;
    logic [7:0] outstanding_reg, outstanding_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_comb begin
        outstanding_next = outstanding_reg;
        if (in_beat && !out_beat) begin
            outstanding_next = outstanding_reg + 8'd1;
        end else if (out_beat && !in_beat) begin
            outstanding_next = outstanding_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg          <= 1'b0;
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
            if (psel && penable && pwrite && pready &&
                lj_reg_t'(paddr[ADDR_W-1:2]) == REG_ENABLE) begin
                en_reg <= pwdata[0];
            end
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat presented right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_energy) && $stable(m_saturated))
        else $error("stalled result beat changed");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> outstanding_reg != 8'd0)
        else $error("result beat without a pending input beat");

    a_disabled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !en_reg |-> m_energy == '0 && !m_saturated)
        else $error("nonzero result while disabled");

endmodule

bind lennard_jones_pair_energy lj_chk u_lj_chk (.*);

/* tb/sv/lj_energy_checker.sv */
`timescale 1ns / 100ps
module lj_energy_checker import lj_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [WORD_W-1:0]          pwdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [WORD_W-1:0]          s_distance,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [ENERGY_W-1:0] m_energy,
    input  logic                       m_saturated,
    output int                         fail_count,
    output int                         due_count
);

    localparam logic [PROD_W-1:0] WORD_MAX = PROD_W'({WORD_W{1'b1}});

    logic              en_q;
    logic [WORD_W-1:0] sigma_q;
    logic [WORD_W-1:0] eps_q;
    logic [WORD_W-1:0] cutoff_q;

    lj_res_t           energy_due[$];
    logic [WORD_W-1:0] distance_due[$];

    // MSB flags saturation, low word is the clipped Q value
    function automatic logic [WORD_W:0] trunc_mul(input logic [PROD_W-1:0] a,
                                                  input logic [PROD_W-1:0] b);
        logic [PROD_W-1:0] p;
        p = (a * b) >> FRAC_BITS;
        if (p > WORD_MAX) begin
            return {1'b1, WORD_MAX[WORD_W-1:0]};
        end
        return {1'b0, p[WORD_W-1:0]};
    endfunction

    function automatic lj_res_t pair_energy(input logic [WORD_W-1:0] r_in);
        logic [PROD_W-1:0] q;
        logic [PROD_W-1:0] q2;
        logic [PROD_W-1:0] q3;
        logic [PROD_W-1:0] s;
        logic [PROD_W-1:0] s2;
        logic [PROD_W-1:0] diff;
        logic [PROD_W-1:0] emag;
        logic [PROD_W-1:0] mag;
        logic [WORD_W:0]   step;
        logic              sat;
        logic              dneg;
        logic              eneg;
        lj_res_t           res;
        res = '0;
        sat = 1'b0;
        if (!en_q || r_in >= cutoff_q) begin
            return res;
        end
        if (r_in == '0) begin
            q   = WORD_MAX;
            sat = 1'b1;
        end else begin
            q = (PROD_W'(sigma_q) << FRAC_BITS) / PROD_W'(r_in);
            if (q > WORD_MAX) begin
                q   = WORD_MAX;
                sat = 1'b1;
            end
        end
        step = trunc_mul(q, q);
        sat  = sat | step[WORD_W];
        q2   = PROD_W'(step[WORD_W-1:0]);
        step = trunc_mul(q2, q);
        sat  = sat | step[WORD_W];
        q3   = PROD_W'(step[WORD_W-1:0]);
        step = trunc_mul(q3, q3);
        sat  = sat | step[WORD_W];
        s    = PROD_W'(step[WORD_W-1:0]);
        step = trunc_mul(s, s);
        sat  = sat | step[WORD_W];
        s2   = PROD_W'(step[WORD_W-1:0]);

        dneg = s2 < s;
        diff = dneg ? (s - s2) : (s2 - s);
        eneg = eps_q[WORD_W-1];
        emag = eneg ? ((PROD_W'(1) << WORD_W) - PROD_W'(eps_q)) : PROD_W'(eps_q);
        mag  = (emag * diff) >> (FRAC_BITS - 2);

        if ((dneg != eneg) && mag != '0) begin
            if (mag > E_NEG_LIM) begin
                mag = E_NEG_LIM;
                sat = 1'b1;
            end
            res.energy = ENERGY_W'(PROD_W'(0) - mag);
        end else begin
            if (mag > E_POS_LIM) begin
                mag = E_POS_LIM;
                sat = 1'b1;
            end
            res.energy = ENERGY_W'(mag);
        end
        res.sat = sat;
        return res;
    endfunction

    always @(posedge aclk) begin
        lj_res_t           want;
        logic [WORD_W-1:0] r_seen;
        if (!aresetn) begin
            en_q     <= 1'b0;
            sigma_q  <= '0;
            eps_q    <= '0;
            cutoff_q <= '0;
            energy_due.delete();
            distance_due.delete();
            due_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (lj_reg_t'(paddr[ADDR_W-1:2]))
                    REG_ENABLE:  en_q     <= pwdata[0];
                    REG_SIGMA:   sigma_q  <= pwdata;
                    REG_EPSILON: eps_q    <= pwdata;
                    REG_CUTOFF:  cutoff_q <= pwdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                energy_due.push_back(pair_energy(s_distance));
                distance_due.push_back(s_distance);
            end
            if (m_valid && m_ready) begin
                if (energy_due.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result beat: energy %h sat %b",
                                 m_energy, m_saturated);
                    end
                    fail_count++;
                end else begin
                    want   = energy_due.pop_front();
                    r_seen = distance_due.pop_front();
                    if (m_energy !== want.energy) begin
                        if (fail_count < 10) begin
                            $display("energy mismatch, r=%h: expected %h, got %h",
                                     r_seen, want.energy, m_energy);
                        end
                        fail_count++;
                    end
                    if (m_saturated !== want.sat) begin
                        if (fail_count < 10) begin
                            $display("saturated mismatch, r=%h: expected %b, got %b",
                                     r_seen, want.sat, m_saturated);
                        end
                        fail_count++;
                    end
                end
            end
            due_count <= energy_due.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
module tb;
    import lj_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int DRAIN       = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int SEG_ITEMS   = 203;
    localparam int SEGMENTS    = 9;

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [WORD_W-1:0]          pwdata;
    logic [WORD_W-1:0]          prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic [WORD_W-1:0]          s_distance;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [ENERGY_W-1:0] m_energy;
    logic                       m_saturated;

    int   fail_count;
    int   due_count;
    int   send_idle = 14;
    int   recv_idle = 57;
    int   cycle_count = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    logic [WORD_W-1:0] unit_probes [0:11] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0001_0000, 32'h0001_1F5A,
        32'h0000_8000, 32'h0000_4000, 32'h0002_0000, 32'h0002_8000,
        32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
    };
    logic [WORD_W-1:0] cutoff_probes [0:4] = '{
        32'h0001_FFFF, 32'h0002_0000, 32'h0002_0001, 32'h0000_0100, 32'h0001_0000
    };
    logic [WORD_W-1:0] deep_probes [0:2] = '{
        32'h0001_0000, 32'h0003_0000, 32'h0001_C000
    };

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    lennard_jones_pair_energy u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_distance  (s_distance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_energy    (m_energy),
        .m_saturated (m_saturated)
    );

    lj_energy_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_distance  (s_distance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_energy    (m_energy),
        .m_saturated (m_saturated),
        .fail_count  (fail_count),
        .due_count   (due_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("lennard_jones_pair_energy verification failed");
            $finish;
        end
    end

    // hold off for a long stretch on request, else stall at random
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic reg_write(input lj_reg_t idx, input logic [WORD_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic apply_config(input logic [WORD_W-1:0] en, input logic [WORD_W-1:0] sig,
                                input logic [WORD_W-1:0] eps, input logic [WORD_W-1:0] cut);
        settle();
        reg_write(REG_ENABLE, en);
        reg_write(REG_SIGMA, sig);
        reg_write(REG_EPSILON, eps);
        reg_write(REG_CUTOFF, cut);
    endtask

    // keep valid up with the same payload until the beat is taken
    task automatic send_distance(input logic [WORD_W-1:0] r_val);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_distance <= r_val;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [WORD_W-1:0] pick_distance(input logic [WORD_W-1:0] sig,
                                                        input logic [WORD_W-1:0] cut);
        int unsigned       sel;
        logic [PROD_W-1:0] scaled;
        sel = $urandom_range(99);
        if (sel < 45) begin
            scaled = (PROD_W'(sig) * PROD_W'($urandom_range(40, 200))) >> 6;
            if (scaled > PROD_W'({WORD_W{1'b1}})) begin
                return '1;
            end
            return scaled[WORD_W-1:0] ^ WORD_W'($urandom_range(7));
        end
        if (sel < 55) begin
            return WORD_W'($urandom_range(255));
        end
        if (sel < 65) begin
            return cut + WORD_W'($urandom_range(4)) - WORD_W'(2);
        end
        if (sel < 70) begin
            return '0;
        end
        return $urandom();
    endfunction

    initial begin
        int                seg;
        logic [WORD_W-1:0] en;
        logic [WORD_W-1:0] sig;
        logic [WORD_W-1:0] eps;
        logic [WORD_W-1:0] cut;
        logic [WORD_W-1:0] eps_mag;
        logic [PROD_W-1:0] cut64;

        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        s_valid    <= 1'b0;
        s_distance <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apply_config(32'd1, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
        foreach (unit_probes[i]) send_distance(unit_probes[i]);
        apply_config(32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0002_0000);
        foreach (cutoff_probes[i]) send_distance(cutoff_probes[i]);
        apply_config(32'd1, 32'h0002_0000, 32'h7FFF_FFFF, 32'h0004_0000);
        foreach (deep_probes[i]) send_distance(deep_probes[i]);
        apply_config(32'hFFFF_FFFE, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
        send_distance(32'h0000_0100);
        send_distance(32'h0000_0000);
        apply_config(32'd1, 32'h0000_0000, 32'h0000_1234, 32'hFFFF_FFFF);
        send_distance(32'h0000_0100);
        send_distance(32'h0000_0000);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            send_idle = (seg < 3) ? 14 : (seg < 6) ? 57 : 0;
            recv_idle = (seg < 3) ? 57 : (seg < 6) ? 14 : 0;

            sig = (seg == 4) ? $urandom() : WORD_W'($urandom_range(32'h8000, 32'h4_0000));
            eps_mag = WORD_W'($urandom_range(32'h3_0000));
            if (seg == 2) begin
                eps = 32'h7FFF_FFFF;
            end else if (seg == 5) begin
                eps = 32'h8000_0000;
            end else if (seg % 2 == 1) begin
                eps = $urandom();
            end else begin
                eps = $urandom_range(1) ? -eps_mag : eps_mag;
            end
            cut64 = (PROD_W'(sig) * 5) >> 1;
            cut   = (cut64 > PROD_W'({WORD_W{1'b1}})) ? '1 : cut64[WORD_W-1:0];
            if (seg == 3) begin
                cut = 32'hFFFF_FFFF;
            end else if (seg == 8) begin
                cut = 32'h0000_0000;
            end
            en = (seg == 7) ? 32'hFFFF_FFFE : 32'd1;

            apply_config(en, sig, eps, cut);
            if (seg == 6) begin
                hold_req = 1'b1;
            end
            repeat (SEG_ITEMS) send_distance(pick_distance(sig, cut));
        end

        settle();
        if (fail_count == 0 && due_count == 0) begin
            $display("lennard_jones_pair_energy verification clean");
        end else begin
            $display("lennard_jones_pair_energy verification failed");
        end
        $finish;
    end

endmodule

/* lennard_jones_pair_energy.f */
sv/lj_pkg.sv
sv/lj_div.sv
sv/lj_fxmul.sv
sv/lennard_jones_pair_energy.sv
sv/lj_chk.sv
tb/sv/lj_energy_checker.sv
tb/sv/tb.sv
